// ===== design/nrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Nonce replay cache package
// Shared sizes, codes and item types for the nonce replay cache.
// ----------------------------------------------------------------------------
package nrc_pkg;

	localparam int ENTRIES         = 16;
	localparam int MAX_NONCE_BYTES = 32;
	localparam int KEY_W           = MAX_NONCE_BYTES * 8;
	localparam int STAMP_W         = 32;
	localparam int IDX_W           = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W           = $clog2(ENTRIES + 1);
	localparam int SLOT_W          = 4;
	localparam logic [31:0] TTL_RESET = 32'd30000 + 32'd1000;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_NOT_SEEN = 3'd0,
		ST_SEEN     = 3'd1,
		ST_STORED   = 3'd2,
		ST_FULL     = 3'd3,
		ST_BAD_LEN  = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] nonce_word0;
		logic [63:0] nonce_word1;
		logic [63:0] nonce_word2;
		logic [63:0] nonce_word3;
		logic [5:0]  nonce_length;
		logic [31:0] now_ms;
		logic [31:0] seen_at_ms;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic live;
		logic hit;
	} match_t;

endpackage

// ===== design/nrc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module nrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/nrc_match.sv =====
// ----------------------------------------------------------------------------
// Nonce replay cache entry check
// Decides whether one stored entry is live and whether it holds the key.
// ----------------------------------------------------------------------------
module nrc_match import nrc_pkg::*; (
	input  logic               valid,
	input  entry_t             entry,
	input  logic [KEY_W-1:0]   key,
	input  logic [STAMP_W-1:0] now_ms,
	input  logic [STAMP_W-1:0] ttl_ms,
	output match_t             result
);

	logic [STAMP_W-1:0] age;

	assign age         = now_ms - entry.stamp;
	assign result.live = valid && (age < ttl_ms);
	assign result.hit  = result.live && (entry.key == key);

endmodule

// ===== design/nonce_replay_cache.sv =====
// ----------------------------------------------------------------------------
// Nonce replay cache
// Table of recently seen nonces with stamps, scanned one entry per cycle.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   start, busy, req         taken when start is high and busy is low
//  result    done, rsp                one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_wdata        ttl written when cfg_we is high
//
// A bad length answers in the cycle after the item is taken.
// Otherwise the entry RAM is read one entry per cycle, each entry at most once,
// stopping early when a lookup hits or an insert finds a free entry.
// Reset clears all valid bits at once; no clearing pass is needed.
// The result cannot be stalled; busy stays high until the item completes.
module nonce_replay_cache import nrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam logic [IDX_W:0]   ENTRIES_X = (IDX_W + 1)'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(ENTRIES - 1);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ENTRIES - 1);

	state_t             state_q, state_d;
	op_t                op_q;
	logic [KEY_W-1:0]   key_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] seen_q;
	logic [31:0]        ttl_q;
	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   next_q;
	logic [IDX_W-1:0]   base_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pend_s1;
	logic               last_s1;
	logic [IDX_W-1:0]   addr_s1;
	logic               done_q;
	rsp_t               rsp_q;

	logic [255:0]       nonce_all;
	logic [KEY_W-1:0]   key_in;
	logic               accept;
	logic               bad_len;
	logic [IDX_W:0]     sum;
	logic [IDX_W-1:0]   rd_idx;
	logic               issue;
	entry_t             rd_entry;
	entry_t             wr_entry;
	match_t             m;
	logic               found;
	logic               finish;
	logic               wr_en;
	logic [IDX_W-1:0]   next_wrap;
	logic [IDX_W+SLOT_W-1:0] slot_ext;
	rsp_t               fin_rsp;

	assign nonce_all = {req.nonce_word3, req.nonce_word2, req.nonce_word1, req.nonce_word0};
	assign bad_len   = (req.nonce_length == 6'd0) ||
		(int'(req.nonce_length) > MAX_NONCE_BYTES);
	assign accept    = start && (state_q == S_IDLE);

	always_comb begin
		for (int b = 0; b < MAX_NONCE_BYTES; b++) begin
			key_in[b*8 +: 8] = (b < int'(req.nonce_length)) ? nonce_all[b*8 +: 8] : 8'h00;
		end
	end

	assign sum    = {1'b0, base_q} + {1'b0, cnt_q[IDX_W-1:0]};
	assign rd_idx = (sum >= ENTRIES_X) ? IDX_W'(sum - ENTRIES_X) : sum[IDX_W-1:0];
	assign issue  = (state_q == S_SCAN) && (cnt_q != CNT_END);

	nrc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_entry),
		.raddr (rd_idx),
		.rdata (rd_entry)
	);

	nrc_match u_match (
		.valid  (valid_q[addr_s1]),
		.entry  (rd_entry),
		.key    (key_q),
		.now_ms (now_q),
		.ttl_ms (ttl_q),
		.result (m)
	);

	assign found     = pend_s1 && ((op_q == OP_INSERT) ? !m.live : m.hit);
	assign finish    = pend_s1 && (found || last_s1);
	assign wr_en     = found && (op_q == OP_INSERT);
	assign wr_entry  = '{key: key_q, stamp: seen_q};
	assign next_wrap = (addr_s1 == IDX_LAST) ? '0 : addr_s1 + 1'b1;
	assign slot_ext  = {{SLOT_W{1'b0}}, addr_s1};

	always_comb begin
		fin_rsp.slot = '0;
		if (op_q == OP_INSERT) begin
			fin_rsp.status = found ? ST_STORED : ST_FULL;
		end else begin
			fin_rsp.status = found ? ST_SEEN : ST_NOT_SEEN;
		end
		if (found) begin
			fin_rsp.slot = slot_ext[SLOT_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !bad_len) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ttl_q   <= TTL_RESET;
			valid_q <= '0;
			next_q  <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ttl_q <= cfg_wdata;
			end
			pend_s1 <= issue && !finish;
			done_q  <= (accept && bad_len) || finish;
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (wr_en) begin
				valid_q[addr_s1] <= 1'b1;
				next_q           <= next_wrap;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			key_q  <= key_in;
			now_q  <= req.now_ms;
			seen_q <= req.seen_at_ms;
			base_q <= (req.op == OP_INSERT) ? next_q : '0;
			rsp_q  <= '{status: ST_BAD_LEN, slot: '0};
		end else if (finish) begin
			rsp_q <= fin_rsp;
		end
		addr_s1 <= rd_idx;
		last_s1 <= (cnt_q == CNT_LAST);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== design/nrc_checker.sv =====
// ----------------------------------------------------------------------------
// Nonce replay cache checker
// Port-level properties of the nonce replay cache, bound to the top level.
// ----------------------------------------------------------------------------
module nrc_checker import nrc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input req_t        req,
	input logic        done,
	input rsp_t        rsp
);

	logic take;
	logic bad;

	assign take = start && !busy;
	assign bad  = (req.nonce_length == 6'd0) ||
		(int'(req.nonce_length) > MAX_NONCE_BYTES);

	a_bad_len_answer: assert property (@(posedge clk) disable iff (!arst_n)
		take && bad |=> done && (rsp.status == ST_BAD_LEN) && (rsp.slot == '0))
		else $error("bad length item not answered at once");

	a_good_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && !bad |=> busy && !done)
		else $error("valid item did not start a scan");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an item");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((rsp.status == ST_NOT_SEEN) || (rsp.status == ST_FULL) ||
		(rsp.status == ST_BAD_LEN)) |-> (rsp.slot == '0))
		else $error("slot not zero on a miss");

endmodule

bind nonce_replay_cache nrc_checker u_nrc_checker (.*);

// ===== dv/nrc_shadow_pkg.sv =====
// ----------------------------------------------------------------------------
// Nonce replay cache shadow
// Software copy of the nonce table and its expiry rules. It keeps the answers
// owed by the block in order and compares each answer that comes back.
// ----------------------------------------------------------------------------
package nrc_shadow_pkg;

	import nrc_pkg::*;

	function automatic logic [KEY_W-1:0] pad_mask(input int unsigned len);
		logic [KEY_W-1:0] m;
		if (len == 0) begin
			return '0;
		end
		if (len >= MAX_NONCE_BYTES) begin
			return '1;
		end
		m = '1;
		return m >> (KEY_W - 8 * len);
	endfunction

	class nrc_shadow_cache;

		logic [31:0]      ttl_ms;
		bit               entry_used[ENTRIES];
		logic [KEY_W-1:0] entry_nonce[ENTRIES];
		logic [31:0]      entry_seen[ENTRIES];
		int unsigned      next_free;
		rsp_t             owed_answers[$];
		int unsigned      mismatches;

		function new();
			ttl_ms = TTL_RESET;
			foreach (entry_used[i]) begin
				entry_used[i] = 1'b0;
			end
			next_free  = 0;
			mismatches = 0;
		endfunction

		function bit is_live(input int unsigned i, input logic [31:0] now);
			logic [31:0] age;
			age = now - entry_seen[i];
			return entry_used[i] && (age < ttl_ms);
		endfunction

		function rsp_t predict_answer(input req_t item);
			rsp_t             ans;
			logic [KEY_W-1:0] key;
			int unsigned      len;
			int unsigned      i;
			int unsigned      n;
			ans.status = ST_NOT_SEEN;
			ans.slot   = '0;
			len        = 32'(item.nonce_length);
			if (len == 0 || len > MAX_NONCE_BYTES) begin
				ans.status = ST_BAD_LEN;
				return ans;
			end
			key = {item.nonce_word3, item.nonce_word2, item.nonce_word1, item.nonce_word0}
				& pad_mask(len);
			if (item.op == OP_LOOKUP) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (is_live(i, item.now_ms) && entry_nonce[i] == key) begin
						ans.status = ST_SEEN;
						ans.slot   = SLOT_W'(i);
						return ans;
					end
				end
				return ans;
			end
			for (n = 0; n < ENTRIES; n++) begin
				i = (next_free + n) % ENTRIES;
				if (!is_live(i, item.now_ms)) begin
					entry_used[i]  = 1'b1;
					entry_nonce[i] = key;
					entry_seen[i]  = item.seen_at_ms;
					next_free      = (i + 1) % ENTRIES;
					ans.status     = ST_STORED;
					ans.slot       = SLOT_W'(i);
					return ans;
				end
			end
			ans.status = ST_FULL;
			return ans;
		endfunction

		function void note_item(input req_t item);
			owed_answers.push_back(predict_answer(item));
		endfunction

		function void check_result(input rsp_t got);
			rsp_t want;
			if (owed_answers.size() == 0) begin
				$error("result with no item outstanding: status %0d slot %0d",
					got.status, got.slot);
				mismatches++;
				return;
			end
			want = owed_answers.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, got %0d", want.slot, got.slot);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return owed_answers.size();
		endfunction

	endclass

endpackage

// ===== dv/nonce_replay_cache_test.sv =====
// ----------------------------------------------------------------------------
// Nonce replay cache testbench
// Drives lookups and inserts with random gaps over several expiry settings and
// checks every answer against a shadow copy of the nonce table.
// ----------------------------------------------------------------------------
module nonce_replay_cache_test;

	timeunit 1ns;
	timeprecision 1ps;

	import nrc_pkg::*;
	import nrc_shadow_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned POOL        = 12;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	nrc_shadow_cache  shadow = new();
	int unsigned      cycle_count = 0;
	bit               no_gaps;
	logic [31:0]      clock_ms;
	logic [KEY_W-1:0] pool_key[POOL];
	int unsigned      pool_len[POOL];

	nonce_replay_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			shadow.check_result(rsp);
		end
	end

	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		for (int i = 0; i < KEY_W / 32; i++) begin
			k[i*32 +: 32] = $urandom;
		end
		return k;
	endfunction

	function automatic req_t build_req(input op_t op, input logic [KEY_W-1:0] key,
		input int unsigned len, input logic [31:0] now, input logic [31:0] seen,
		input bit garble);
		req_t             r;
		logic [KEY_W-1:0] m;
		logic [KEY_W-1:0] words;
		m     = pad_mask(len);
		words = key & m;
		if (garble) begin
			words |= rand_key() & ~m;
		end
		r.op = op;
		{r.nonce_word3, r.nonce_word2, r.nonce_word1, r.nonce_word0} = words;
		r.nonce_length = 6'(len);
		r.now_ms       = now;
		r.seen_at_ms   = seen;
		return r;
	endfunction

	task automatic send_item(input req_t item);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req   <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		shadow.note_item(item);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (shadow.pending() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_ttl(input logic [31:0] value);
		@(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow.ttl_ms = value;
	endtask

	task automatic run_phase(input logic [31:0] ttl, input int unsigned count);
		int unsigned      k;
		int unsigned      pick;
		int unsigned      idx;
		int unsigned      len;
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [31:0]      seen;
		logic [31:0]      step_max;
		step_max = (ttl < 8) ? 32'd2 : ((ttl > 100000) ? 32'd5000 : ttl / 6);
		drain();
		write_ttl(ttl);
		for (k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 39) == 0) begin
				clock_ms = $urandom;
			end else begin
				clock_ms += $urandom_range(0, step_max);
			end
			op   = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				idx = $urandom_range(0, POOL - 1);
				key = pool_key[idx];
				len = pool_len[idx];
			end else if (pick < 93) begin
				key = rand_key();
				len = $urandom_range(1, MAX_NONCE_BYTES);
			end else begin
				key = rand_key();
				len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_NONCE_BYTES + 1, 63);
			end
			case ($urandom_range(0, 3))
				0, 1: seen = clock_ms;
				2: seen = clock_ms - $urandom_range(0, step_max);
				default: seen = $urandom;
			endcase
			send_item(build_req(op, key, len, clock_ms, seen, $urandom_range(0, 1)));
			if ($urandom_range(0, 59) == 0) begin
				drain();
			end
		end
	endtask

	initial begin
		logic [KEY_W-1:0] dk[ENTRIES];
		int unsigned      dl[ENTRIES];
		logic [31:0]      t0;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		no_gaps   = 1'b0;
		t0        = 32'd5000;
		clock_ms  = t0;
		for (int i = 0; i < POOL; i++) begin
			pool_key[i] = rand_key();
			case ($urandom_range(0, 3))
				0: pool_len[i] = 1;
				1: pool_len[i] = MAX_NONCE_BYTES;
				default: pool_len[i] = $urandom_range(1, MAX_NONCE_BYTES);
			endcase
		end
		for (int i = 0; i < ENTRIES; i++) begin
			dk[i] = rand_key();
			dl[i] = $urandom_range(1, MAX_NONCE_BYTES);
		end
		dl[0] = 1;
		dk[1] = '1;
		dl[1] = MAX_NONCE_BYTES;
		dk[2] = '0;
		dl[2] = MAX_NONCE_BYTES;
		dk[3] = dk[3] & pad_mask(3);
		dl[3] = 4;
		dk[4] = '1;
		dl[4] = MAX_NONCE_BYTES;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Bad lengths for both operations, then a lookup on the empty table.
		send_item(build_req(OP_LOOKUP, rand_key(), 0, clock_ms, clock_ms, 1'b1));
		send_item(build_req(OP_INSERT, rand_key(), MAX_NONCE_BYTES + 1, clock_ms,
			clock_ms, 1'b1));
		send_item(build_req(OP_INSERT, '1, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		send_item(build_req(OP_LOOKUP, '1, MAX_NONCE_BYTES, clock_ms, clock_ms, 1'b0));

		// Fill the table, with one nonce stored twice, then overflow it.
		for (int i = 0; i < ENTRIES; i++) begin
			send_item(build_req(OP_INSERT, dk[i], dl[i], clock_ms, clock_ms, 1'b1));
		end
		send_item(build_req(OP_INSERT, rand_key(), 8, clock_ms, clock_ms, 1'b1));
		send_item(build_req(OP_LOOKUP, dk[1], dl[1], clock_ms, clock_ms, 1'b0));
		send_item(build_req(OP_LOOKUP, dk[3], 3, clock_ms, clock_ms, 1'b1));

		// Ageing: one millisecond short of the limit, then exactly at it.
		send_item(build_req(OP_LOOKUP, dk[0], 1, t0 + 32'd30999, t0, 1'b1));
		clock_ms = t0 + TTL_RESET;
		send_item(build_req(OP_LOOKUP, dk[0], 1, clock_ms, clock_ms, 1'b1));
		send_item(build_req(OP_INSERT, dk[5], dl[5], clock_ms, clock_ms, 1'b1));

		// Stamp at the top of the time range, looked up after the wrap.
		send_item(build_req(OP_INSERT, '1, MAX_NONCE_BYTES, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b0));
		send_item(build_req(OP_LOOKUP, '1, MAX_NONCE_BYTES, 32'h0000_0000,
			32'h0000_0000, 1'b0));

		run_phase(32'd1, 100);
		run_phase(32'd0, 40);
		run_phase(32'hFFFF_FFFF, 150);
		run_phase(TTL_RESET, 150);
		run_phase($urandom_range(50, 2000), 160);
		run_phase($urandom_range(1, 20), 130);

		drain();
		repeat (ENTRIES + 4) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
